// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising aclk edge, skipped while aresetn is low.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check a property on every rising aclk edge, during reset too.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/b3c_pkg.sv =====
// Types, constants and the half-mix function of the BLAKE3 compression block.
// Depends on nothing.
package b3c_pkg;

    typedef logic [31:0] word_t;

    typedef enum logic [1:0] {
        ACT_LOAD_CHAIN = 2'd0,
        ACT_LOAD_MSG   = 2'd1,
        ACT_COMPRESS   = 2'd2,
        ACT_NONE       = 2'd3
    } action_t;

    localparam int unsigned NUM_ROUNDS = 7;
    localparam int unsigned IN_TDATA_W  = 120;
    localparam int unsigned OUT_TDATA_W = 40;

    localparam word_t IV [4] = '{32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A};

    localparam logic [3:0] PERM [16] = '{4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
                                         4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8};

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } quad_t;

    // One half of G: second half uses rotations 8 and 7 instead of 16 and 12.
    function automatic quad_t half_mix(input quad_t q, input word_t m, input logic second);
        quad_t r;
        word_t t;
        r.a = q.a + q.b + m;
        t = r.a ^ q.d;
        r.d = second ? {t[7:0], t[31:8]} : {t[15:0], t[31:16]};
        r.c = q.c + r.d;
        t = q.b ^ r.c;
        r.b = second ? {t[6:0], t[31:7]} : {t[11:0], t[31:12]};
        return r;
    endfunction

endpackage

// ===== hw/rtl/blake3_compression.sv =====
// BLAKE3 compression block: chaining and message stores, round engine, output stage.
// Depends on b3c_pkg and assert_macros.svh.
//
//  channel | direction | tdata (low bit up)                                 | tuser  | tlast
//  s_      | in        | word_index, word_data, block_counter, length, flags | action | -
//  m_      | out       | out_index, out_word                                | -      | last_word
//
// A load request writes the chaining or message memory.
// A compress request reads both memories (one word a cycle from the message
// memory port), runs 112 half-G steps (7 rounds x 16), then sends 16 output
// words, one word per cycle while m_tready stays high.
// Reset clears only control state; the memories stay unknown until written.
// A stalled output holds the engine; s_tready drops for the whole compress.
`include "assert_macros.svh"

module blake3_compression (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // word_index[3:0], word_data[35:4], block_counter[99:36],
    // block_length[106:100], domain_flags[114:107], zero fill
    input  logic [b3c_pkg::IN_TDATA_W-1:0]  s_tdata,
    // action[1:0]
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_index[3:0], out_word[35:4], zero fill
    output logic [b3c_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import b3c_pkg::*;

    typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_MIX, ST_OUT} state_t;

    word_t chain_mem [8];
    word_t msg_mem [16];
    word_t chain_rd_reg, msg_rd_reg;

    state_t state_reg;
    logic [4:0] cnt_reg;
    logic [3:0] step_reg;
    logic [2:0] round_reg;
    word_t v_reg [16];
    word_t m_reg [16];
    word_t cv_reg [8];
    logic [63:0] ctr_reg;
    logic [6:0] len_reg;
    logic [7:0] flags_reg;
    logic m_valid_reg, m_last_reg;
    logic [OUT_TDATA_W-1:0] m_data_reg;

    logic s_fire;
    action_t act;
    logic [3:0] in_idx;
    word_t in_data;
    quad_t q_in, q_out;
    word_t v_g [16], v_rot [16], m_sh [16], m_perm [16];
    logic [1:0] rot_amt [4];
    logic out_go;
    word_t out_word;

    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign act      = action_t'(s_tuser);
    assign in_idx   = s_tdata[3:0];
    assign in_data  = s_tdata[35:4];
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign out_go   = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    // Memory writes from load requests; one registered read per memory.
    always_ff @(posedge aclk) begin
        if (s_fire && act == ACT_LOAD_CHAIN && !in_idx[3]) begin
            chain_mem[in_idx[2:0]] <= in_data;
        end
        if (s_fire && act == ACT_LOAD_MSG) begin
            msg_mem[in_idx] <= in_data;
        end
        chain_rd_reg <= chain_mem[cnt_reg[2:0]];
        msg_rd_reg   <= msg_mem[cnt_reg[3:0]];
    end

    // The G unit always works on column zero; rows are rotated after every second half-G step.
    always_comb begin
        q_in = '{a: v_reg[0], b: v_reg[4], c: v_reg[8], d: v_reg[12]};
        q_out = half_mix(q_in, m_reg[0], step_reg[0]);
        for (int i = 0; i < 16; i++) begin
            v_g[i] = v_reg[i];
        end
        v_g[0]  = q_out.a;
        v_g[4]  = q_out.b;
        v_g[8]  = q_out.c;
        v_g[12] = q_out.d;
        for (int r = 0; r < 4; r++) begin
            if (step_reg == 4'd7) begin
                rot_amt[r] = 2'(r + 1);
            end else if (step_reg == 4'd15) begin
                rot_amt[r] = 2'(1 - r);
            end else begin
                rot_amt[r] = 2'd1;
            end
        end
        for (int r = 0; r < 4; r++) begin
            for (int j = 0; j < 4; j++) begin
                v_rot[4*r+j] = v_g[{r[1:0], 2'(j[1:0] + rot_amt[r])}];
            end
        end
        for (int i = 0; i < 16; i++) begin
            m_sh[i] = m_reg[(i + 1) % 16];
        end
        for (int i = 0; i < 16; i++) begin
            m_perm[i] = m_sh[PERM[i]];
        end
        out_word = cnt_reg[3] ? (v_reg[0] ^ cv_reg[0]) : (v_reg[0] ^ v_reg[8]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            step_reg    <= '0;
            round_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_last_reg  <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    cnt_reg <= '0;
                    if (s_fire && act == ACT_COMPRESS) begin
                        ctr_reg   <= s_tdata[99:36];
                        len_reg   <= s_tdata[106:100];
                        flags_reg <= s_tdata[114:107];
                        state_reg <= ST_LOAD;
                    end
                end
                ST_LOAD: begin
                    // Shift read data in; address cnt, data arrives for cnt-1.
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg != 5'd0) begin
                        for (int i = 0; i < 15; i++) begin
                            m_reg[i] <= m_reg[i+1];
                        end
                        m_reg[15] <= msg_rd_reg;
                        if (cnt_reg <= 5'd8) begin
                            for (int i = 0; i < 7; i++) begin
                                cv_reg[i] <= cv_reg[i+1];
                            end
                            cv_reg[7] <= chain_rd_reg;
                        end
                    end
                    if (cnt_reg == 5'd16) begin
                        for (int i = 0; i < 8; i++) begin
                            v_reg[i] <= cv_reg[i];
                        end
                        for (int i = 0; i < 4; i++) begin
                            v_reg[8+i] <= IV[i];
                        end
                        v_reg[12] <= ctr_reg[31:0];
                        v_reg[13] <= ctr_reg[63:32];
                        v_reg[14] <= {25'd0, len_reg};
                        v_reg[15] <= {24'd0, flags_reg};
                        step_reg  <= '0;
                        round_reg <= '0;
                        state_reg <= ST_MIX;
                    end
                end
                ST_MIX: begin
                    // Advance one half-G; rotate rows after the second half.
                    step_reg <= step_reg + 4'd1;
                    if (!step_reg[0]) begin
                        v_reg <= v_g;
                    end else begin
                        v_reg <= v_rot;
                    end
                    if (step_reg == 4'd15) begin
                        m_reg <= m_perm;
                        if (round_reg == 3'(NUM_ROUNDS - 1)) begin
                            round_reg <= '0;
                            cnt_reg   <= '0;
                            state_reg <= ST_OUT;
                        end else begin
                            round_reg <= round_reg + 3'd1;
                        end
                    end else begin
                        m_reg <= m_sh;
                    end
                end
                ST_OUT: begin
                    if (out_go) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {4'd0, out_word, cnt_reg[3:0]};
                        m_last_reg  <= (cnt_reg[3:0] == 4'd15);
                        cnt_reg     <= cnt_reg + 5'd1;
                        for (int i = 0; i < 15; i++) begin
                            v_reg[i] <= v_reg[i+1];
                        end
                        v_reg[15] <= v_reg[0];
                        if (cnt_reg[3]) begin
                            for (int i = 0; i < 7; i++) begin
                                cv_reg[i] <= cv_reg[i+1];
                            end
                            cv_reg[7] <= cv_reg[0];
                        end
                        if (cnt_reg[3:0] == 4'd15) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_round_idle, (state_reg != ST_MIX) |-> (round_reg == 3'd0), "round count left nonzero")
    `ASSERT_CLK(a_compress_start, (s_fire && act == ACT_COMPRESS) |=> (state_reg == ST_LOAD), "compress did not start load")
    `ASSERT_CLK(a_last_idle, (out_go && cnt_reg[3:0] == 4'd15) |=> (m_tlast && state_reg == ST_IDLE), "last word not marked")
    `ASSERT_CLK(a_no_out_busy, (state_reg == ST_LOAD || state_reg == ST_MIX) |-> !s_tready, "request taken while busy")

endmodule
